@@ rtl/lpsa_pkg.sv @@
`default_nettype none
package lpsa_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int SIZE_W = SLOT_W + 1;
  localparam int CFG_W = 11;
  localparam int ID_W = 31;

  // The used marks are kept as words of WORD_W slots each.
  localparam int WORD_W = 32;
  localparam int WORD_IDX_W = $clog2(WORD_W);
  localparam int ROWS = MAX_SLOTS / WORD_W;
  localparam int ROW_W = $clog2(ROWS);

  // The remainder unit retires DIV_STEP dividend bits per cycle.
  localparam int DIV_STEP = 4;
  localparam int DIV_ITERS = (ID_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_PAD_W = DIV_ITERS * DIV_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = CFG_W'(1024);

  typedef struct packed {
    logic [ID_W-1:0] user_id;
    logic            last_of_batch;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              full_res;
  } res_t;

  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    logic             clr;
  } bm_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/lpsa_divider.sv @@
`default_nettype none
module lpsa_divider
  import lpsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [ID_W-1:0]   dividend,
  input  wire logic [SIZE_W-1:0] divisor,
  output logic                   done,
  output logic [SLOT_W-1:0]      rem
);

  logic                 active;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_PAD_W-1:0] dvd;
  logic [SIZE_W-1:0]    dsr;
  logic [SLOT_W-1:0]    rem_next;

  // Restoring remainder steps: the partial remainder stays below the divisor,
  // so one compare and subtract per bit keeps it in range.
  always_comb begin
    logic [SIZE_W-1:0] t;
    t = {1'b0, rem};
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {t[SLOT_W-1:0], dvd[DIV_PAD_W-1-i]};
      if (t >= dsr) begin
        t = t - dsr;
      end
    end
    rem_next = t[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        dvd    <= DIV_PAD_W'(dividend);
        dsr    <= divisor;
        rem    <= '0;
      end else if (active) begin
        rem <= rem_next;
        dvd <= dvd << DIV_STEP;
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_ITERS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/lpsa_bitmap.sv @@
`default_nettype none
module lpsa_bitmap
  import lpsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bm_ctrl_t          ctrl,
  input  wire logic [WORD_W-1:0] wdata,
  output logic [WORD_W-1:0]      rdata
);

  logic [WORD_W-1:0] mem [ROWS];
  logic [WORD_W-1:0] rdata_raw;
  logic [ROWS-1:0]   row_valid;
  logic              rd_valid;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_row] <= wdata;
    end
    if (ctrl.rd_en) begin
      rdata_raw <= mem[ctrl.rd_row];
    end
  end

  // A word not written since the last clear reads as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (ctrl.rd_en) begin
        rd_valid <= row_valid[ctrl.rd_row];
      end
      if (ctrl.clr) begin
        row_valid <= '0;
      end else if (ctrl.wr_en) begin
        row_valid[ctrl.wr_row] <= 1'b1;
      end
    end
  end

  assign rdata = rd_valid ? rdata_raw : '0;

endmodule
`default_nettype wire

@@ rtl/linear_probe_slot_allocator_unit.sv @@
// Linear-probing slot allocator.
// An item is accepted when start is high and busy is low; req carries the
// requester id and the last-of-batch flag. The home slot is the id modulo the
// table size, and the first free slot at or above it (wrapping) is marked used.
// The result appears on res, marked by done for exactly one cycle; the
// receiver takes it in that cycle and cannot stall it. busy stays high from
// acceptance until the cycle that done is shown, so items are handled one at
// a time.
// Steps: the remainder unit retires 4 id bits a cycle; the remainder is then
// handed to the search, and each 32-slot word of the bitmap takes a memory
// read, then a search. Each further word visited adds one more read and
// search, up to a full table of 1024 slots. The next item can be accepted
// at the edge that takes the result.
// The table size is written through cfg_valid/cfg_data, always ready; it
// must only change while no item is in flight.
// Reset sets the table size to 1024 and marks every slot free at once; the
// same clear follows an item with last_of_batch set.
`default_nettype none
module linear_probe_slot_allocator_unit
  import lpsa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire req_t             req,
  output logic                  done,
  output res_t                  res,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_CHECK
  } state_t;

  state_t              state;
  logic [CFG_W-1:0]    table_size;
  logic [SIZE_W-1:0]   eff_size;
  logic [SIZE_W-1:0]   size_q;
  logic                last_q;
  logic [ROW_W-1:0]    home_row;
  logic [ROW_W-1:0]    row;
  logic [WORD_IDX_W-1:0] home_off;
  logic                first;
  logic                wrapped;

  logic                div_done;
  logic [SLOT_W-1:0]   div_rem;
  logic                accept;

  bm_ctrl_t            bm_ctrl;
  logic [WORD_W-1:0]   bm_rdata;
  logic [WORD_W-1:0]   bm_wdata;

  logic [WORD_W-1:0]     free_bits;
  logic                  found;
  logic [WORD_IDX_W-1:0] pick;
  logic [SIZE_W-1:0]     next_start;
  logic                  wrap_now;
  logic                  give_up;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    eff_size = SIZE_W'(table_size);
    if (table_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if (32'(table_size) > 32'(MAX_SLOTS)) begin
      eff_size = SIZE_W'(MAX_SLOTS);
    end
  end

  lpsa_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (req.user_id),
    .divisor  (eff_size),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Search of the word just read: on the first visit only bits from the home
  // offset up count, and slots at or beyond the table size never count.
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      free_bits[b] = !bm_rdata[b]
                     && ({1'b0, row, WORD_IDX_W'(b)} < size_q)
                     && (!first || (WORD_IDX_W'(b) >= home_off));
    end
    found = |free_bits;
    pick  = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        pick = WORD_IDX_W'(b);
      end
    end
    next_start = {({1'b0, row} + 1'b1), {WORD_IDX_W{1'b0}}};
    wrap_now   = (next_start >= size_q);
    // Back at the home word after wrapping: every slot has been seen.
    give_up    = wrapped && (row == home_row);
  end

  always_comb begin
    bm_ctrl.rd_en  = (state == ST_READ);
    bm_ctrl.rd_row = row;
    bm_ctrl.wr_en  = (state == ST_CHECK) && found;
    bm_ctrl.wr_row = row;
    bm_ctrl.clr    = (state == ST_CHECK) && (found || give_up) && last_q;
    bm_wdata       = bm_rdata | (WORD_W'(1) << pick);
  end

  lpsa_bitmap u_bitmap (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (bm_ctrl),
    .wdata (bm_wdata),
    .rdata (bm_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      table_size <= TABLE_SIZE_RST;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        table_size <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            size_q <= eff_size;
            last_q <= req.last_of_batch;
            state  <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            home_row <= div_rem[SLOT_W-1:WORD_IDX_W];
            row      <= div_rem[SLOT_W-1:WORD_IDX_W];
            home_off <= div_rem[WORD_IDX_W-1:0];
            first    <= 1'b1;
            wrapped  <= 1'b0;
            state    <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (found) begin
            res.slot     <= {row, pick};
            res.full_res <= 1'b0;
            done         <= 1'b1;
            state        <= ST_IDLE;
          end else if (give_up) begin
            res.slot     <= '0;
            res.full_res <= 1'b1;
            done         <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            first <= 1'b0;
            if (wrap_now) begin
              row     <= '0;
              wrapped <= 1'b1;
            end else begin
              row <= row + 1'b1;
            end
            state <= ST_READ;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_from_check: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_CHECK))
    else $error("result shown without a finished search");

  a_full_slot_zero: assert property (@(posedge clk) disable iff (rst)
    done && res.full_res |-> res.slot == '0)
    else $error("full result carries a nonzero slot");

  a_slot_in_table: assert property (@(posedge clk) disable iff (rst)
    done && !res.full_res |-> {1'b0, res.slot} < size_q)
    else $error("allocated slot lies outside the table");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !done)
    else $error("accepted item did not make the block busy");

  a_write_found: assert property (@(posedge clk) disable iff (rst)
    bm_ctrl.wr_en |=> done && !res.full_res)
    else $error("bitmap written without an allocation result");

endmodule
`default_nettype wire
